// ----- rtl/core/ttdac_pkg.sv -----
// shared types, constants and curve tables for the tap tempo dac controller
// no dependencies
`timescale 1ns / 1ps

package ttdac_pkg;

    localparam int CURVE_POINTS  = 21;
    localparam int ELAPSED_LIMIT = 1000;
    localparam int CIDX_W        = $clog2(CURVE_POINTS);
    localparam int QUEUE_DEPTH   = 2;

    localparam logic [9:0]  TIMEOUT_RST = 10'd900;
    localparam logic [7:0]  TPM_RST     = 8'd62;
    localparam logic [9:0]  HYST_RST    = 10'd10;
    localparam logic [11:0] DAC_MAX     = 12'd4095;
    localparam logic [10:0] IVL_MAX     = 11'd2047;

    localparam logic [1:0] KIND_TICK = 2'd0;
    localparam logic [1:0] KIND_TAP  = 2'd1;
    localparam logic [1:0] KIND_POT  = 2'd2;

    localparam logic [1:0] CFG_TIMEOUT = 2'd0;
    localparam logic [1:0] CFG_TPM     = 2'd1;
    localparam logic [1:0] CFG_HYST    = 2'd2;

    // work handed from front to back
    typedef enum logic {
        t_JOB_POT = 1'b0,
        t_JOB_TAP = 1'b1
    } t_job_kind;

    typedef struct packed {
        t_job_kind   kind;
        logic [15:0] delta;
        logic [9:0]  pot;
        logic [7:0]  div;
    } t_job;

    typedef enum logic [2:0] {
        t_ST_IDLE,
        t_ST_DIV,
        t_ST_SEARCH,
        t_ST_MUL,
        t_ST_FRAC,
        t_ST_OUT
    } t_back_state;

    function automatic logic [9:0] curve_ms(input logic [CIDX_W-1:0] i);
        logic [9:0] v;
        case (i)
            5'd0: v = 10'd842;   5'd1: v = 10'd836;   5'd2: v = 10'd821;
            5'd3: v = 10'd794;   5'd4: v = 10'd763;   5'd5: v = 10'd728;
            5'd6: v = 10'd692;   5'd7: v = 10'd653;   5'd8: v = 10'd612;
            5'd9: v = 10'd570;   5'd10: v = 10'd524;  5'd11: v = 10'd478;
            5'd12: v = 10'd427;  5'd13: v = 10'd374;  5'd14: v = 10'd318;
            5'd15: v = 10'd257;  5'd16: v = 10'd195;  5'd17: v = 10'd127;
            5'd18: v = 10'd77;   5'd19: v = 10'd57;   5'd20: v = 10'd47;
            default: v = 10'd0;
        endcase
        return v;
    endfunction

    function automatic logic [12:0] curve_code(input logic [CIDX_W-1:0] i);
        logic [12:0] v;
        case (i)
            5'd0: v = 13'd0;     5'd1: v = 13'd206;   5'd2: v = 13'd414;
            5'd3: v = 13'd622;   5'd4: v = 13'd824;   5'd5: v = 13'd1035;
            5'd6: v = 13'd1235;  5'd7: v = 13'd1442;  5'd8: v = 13'd1647;
            5'd9: v = 13'd1850;  5'd10: v = 13'd2059; 5'd11: v = 13'd2260;
            5'd12: v = 13'd2468; 5'd13: v = 13'd2671; 5'd14: v = 13'd2875;
            5'd15: v = 13'd3080; 5'd16: v = 13'd3285; 5'd17: v = 13'd3490;
            5'd18: v = 13'd3695; 5'd19: v = 13'd3899; 5'd20: v = 13'd4096;
            default: v = 13'd0;
        endcase
        return v;
    endfunction

endpackage

// ----- rtl/core/ttdac_front.sv -----
// front end: registers, ms counter, tap and pot classification
// depends on ttdac_pkg
`timescale 1ns / 1ps

module ttdac_front import ttdac_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_kind,
    input  logic [15:0] i_capture_time,
    input  logic [9:0]  i_pot_value,
    output logic        o_job_valid,
    input  logic        i_job_ready,
    output t_job        o_job
);

    logic [9:0]  r_timeout;
    logic [7:0]  r_tpm;
    logic [9:0]  r_hyst;
    logic [15:0] r_last_cap;
    logic [9:0]  r_elapsed;
    logic        r_await;
    logic        r_pot_mode;
    logic [9:0]  r_saved_pot;

    logic        accept;
    logic        restart;
    logic [10:0] diff_pos;
    logic [10:0] diff_neg;
    logic        big_move;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = i_job_ready;
    assign accept      = i_in_valid && i_job_ready;
    assign restart     = r_await || (r_elapsed >= r_timeout);
    assign diff_pos    = {1'b0, i_pot_value} - {1'b0, r_saved_pot};
    assign diff_neg    = {1'b0, r_saved_pot} - {1'b0, i_pot_value};
    assign big_move    = (i_pot_value > r_saved_pot) ? (diff_pos[9:0] > r_hyst)
                                                     : (diff_neg[9:0] > r_hyst);

    always_comb begin
        o_job_valid = 1'b0;
        o_job.kind  = t_JOB_POT;
        o_job.delta = i_capture_time - r_last_cap;
        o_job.pot   = i_pot_value;
        o_job.div   = (r_tpm == 8'd0) ? 8'd1 : r_tpm;
        if (i_in_valid) begin
            case (i_kind)
                KIND_TAP: begin
                    o_job_valid = !restart;
                    o_job.kind  = t_JOB_TAP;
                end
                KIND_POT: o_job_valid = r_pot_mode;
                default:  o_job_valid = 1'b0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout   <= TIMEOUT_RST;
            r_tpm       <= TPM_RST;
            r_hyst      <= HYST_RST;
            r_last_cap  <= '0;
            r_elapsed   <= '0;
            r_await     <= 1'b1;
            r_pot_mode  <= 1'b1;
            r_saved_pot <= '0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_TIMEOUT: r_timeout <= i_cfg_data[9:0];
                    CFG_TPM:     r_tpm     <= i_cfg_data[7:0];
                    CFG_HYST:    r_hyst    <= i_cfg_data[9:0];
                    default:     ;
                endcase
            end
            if (accept) begin
                case (i_kind)
                    KIND_TICK: begin
                        if (r_elapsed < 10'(ELAPSED_LIMIT)) r_elapsed <= r_elapsed + 10'd1;
                    end
                    KIND_TAP: begin
                        r_last_cap <= i_capture_time;
                        r_elapsed  <= '0;
                        r_await    <= 1'b0;
                        if (!restart) r_pot_mode <= 1'b0;
                    end
                    KIND_POT: begin
                        if (r_pot_mode) r_saved_pot <= i_pot_value;
                        else if (big_move) r_pot_mode <= 1'b1;
                    end
                    default: ;
                endcase
            end
        end
    end

endmodule

// ----- rtl/core/ttdac_queue.sv -----
// short job queue between front and back
// depends on ttdac_pkg
`timescale 1ns / 1ps

module ttdac_queue import ttdac_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_wr_valid,
    output logic o_wr_ready,
    input  t_job i_wr_job,
    output logic o_rd_valid,
    input  logic i_rd_ready,
    output t_job o_rd_job
);

    localparam int PW = $clog2(QUEUE_DEPTH);

    t_job          r_mem [QUEUE_DEPTH];
    logic [PW-1:0] r_wp;
    logic [PW-1:0] r_rp;
    logic [PW:0]   r_cnt;
    logic          wr;
    logic          rd;

    assign o_wr_ready = (r_cnt < (PW+1)'(QUEUE_DEPTH));
    assign o_rd_valid = (r_cnt != '0);
    assign o_rd_job   = r_mem[r_rp];
    assign wr         = i_wr_valid && o_wr_ready;
    assign rd         = o_rd_valid && i_rd_ready;

    always_ff @(posedge i_clk) begin
        if (wr) r_mem[r_wp] <= i_wr_job;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (wr) r_wp <= (r_wp == PW'(QUEUE_DEPTH-1)) ? '0 : r_wp + 1'b1;
            if (rd) r_rp <= (r_rp == PW'(QUEUE_DEPTH-1)) ? '0 : r_rp + 1'b1;
            r_cnt <= r_cnt + (PW+1)'(wr) - (PW+1)'(rd);
        end
    end

endmodule

// ----- rtl/core/ttdac_back.sv -----
// back end: serial divide, curve search, interpolation and output register
// depends on ttdac_pkg
`timescale 1ns / 1ps

module ttdac_back import ttdac_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_job_valid,
    output logic        o_job_ready,
    input  t_job        i_job,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [11:0] o_dac_code,
    output logic        o_source,
    output logic [10:0] o_interval_ms
);

    t_back_state       r_st, n_st;
    logic [15:0]       r_rem;      // dividend shifts out, quotient shifts in
    logic [8:0]        r_part;
    logic [4:0]        r_cnt;
    logic [7:0]        r_div;
    logic [CIDX_W-1:0] r_idx;
    logic [22:0]       r_num;
    logic [9:0]        r_den;
    logic [12:0]       r_y0;
    logic [11:0]       r_code;
    logic [11:0]       r_o_code;
    logic              r_o_src;
    logic [10:0]       r_o_ivl;
    logic              r_o_valid;
    logic              r_st_tap;

    logic [8:0]  trial;
    logic [8:0]  sub;
    logic [15:0] q;
    logic [9:0]  x0;
    logic [9:0]  x1;
    logic [12:0] dy;
    logic [9:0]  dx;
    logic [10:0] tr;
    logic [10:0] df;
    logic [13:0] y;

    assign q     = r_rem;
    assign trial = {r_part[7:0], r_rem[15]};
    assign sub   = trial - {1'b0, r_div};
    assign x0    = curve_ms(r_idx - 1'b1);
    assign x1    = curve_ms(r_idx);
    assign dy    = curve_code(r_idx) - curve_code(r_idx - 1'b1);
    assign dx    = x0 - q[9:0];
    assign tr    = {1'b0, r_part, r_num[22]};
    assign df    = tr - {1'b0, r_den};
    // final quotient bit joins the low bits on the last step
    assign y     = {1'b0, r_y0} + {1'b0, r_num[11:0], ~df[10]};

    assign o_job_ready  = (r_st == t_ST_IDLE);
    assign o_valid      = r_o_valid;
    assign o_dac_code   = r_o_code;
    assign o_source     = r_o_src;
    assign o_interval_ms = r_o_ivl;

    always_comb begin
        n_st = r_st;
        case (r_st)
            t_ST_IDLE:   if (i_job_valid) n_st = (i_job.kind == t_JOB_TAP) ? t_ST_DIV : t_ST_OUT;
            t_ST_DIV:    if (r_cnt == 5'd15) n_st = t_ST_SEARCH;
            t_ST_SEARCH: begin
                if (q > 16'd842 || q <= 16'd47) n_st = t_ST_OUT;
                else if (x1 < q[9:0]) n_st = t_ST_MUL;
            end
            t_ST_MUL:    n_st = t_ST_FRAC;
            t_ST_FRAC:   if (r_cnt == 5'd22) n_st = t_ST_OUT;
            t_ST_OUT:    if (!r_o_valid || i_ready) n_st = t_ST_IDLE;
            default:     n_st = t_ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_st <= t_ST_IDLE;
        else          r_st <= n_st;
    end

    always_ff @(posedge i_clk) begin
        case (r_st)
            t_ST_IDLE: begin
                r_rem  <= i_job.delta;
                r_div  <= i_job.div;
                r_part <= '0;
                r_cnt  <= '0;
                r_idx  <= CIDX_W'(1);
                r_code <= {i_job.pot, 2'b00};
            end
            t_ST_DIV: begin
                r_cnt <= r_cnt + 5'd1;
                if (!sub[8]) begin
                    r_part <= sub;
                    r_rem  <= {r_rem[14:0], 1'b1};
                end else begin
                    r_part <= trial;
                    r_rem  <= {r_rem[14:0], 1'b0};
                end
            end
            t_ST_SEARCH: begin
                if (q > 16'd842) r_code <= '0;
                else if (q <= 16'd47) r_code <= DAC_MAX;
                else if (x1 < q[9:0]) begin
                    r_den <= x0 - x1;
                    r_y0  <= curve_code(r_idx - 1'b1);
                    r_num <= 23'(dy) * 23'(dx);
                end else r_idx <= r_idx + 1'b1;
                r_cnt <= '0;
            end
            t_ST_MUL: begin
                r_part <= '0;
                r_cnt  <= 5'd0;
            end
            t_ST_FRAC: begin
                // restoring divide of r_num by r_den, quotient into r_num low bits
                r_cnt <= r_cnt + 5'd1;
                if (!df[10]) begin
                    r_part <= df[8:0];
                    r_num  <= {r_num[21:0], 1'b1};
                end else begin
                    r_part <= tr[8:0];
                    r_num  <= {r_num[21:0], 1'b0};
                end
                if (r_cnt == 5'd22) r_code <= (y > 14'(DAC_MAX)) ? DAC_MAX : y[11:0];
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_o_valid <= 1'b0;
        else if (r_st == t_ST_OUT && (!r_o_valid || i_ready)) r_o_valid <= 1'b1;
        else if (i_ready) r_o_valid <= 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (r_st == t_ST_OUT && (!r_o_valid || i_ready)) begin
            r_o_code <= r_code;
            r_o_src  <= r_st_tap;
            r_o_ivl  <= r_st_tap ? ((q > 16'(IVL_MAX)) ? IVL_MAX : q[10:0]) : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_st == t_ST_IDLE && i_job_valid) r_st_tap <= (i_job.kind == t_JOB_TAP);
    end

endmodule

// ----- rtl/core/tap_tempo_to_dac_controller.sv -----
// channel   dir  handshake             payload
// s_axis    in   s_axis_tvalid/tready  tdata {pot_value, capture_time}, tuser kind
// m_axis    out  m_axis_tvalid/tready  tdata {interval_ms, dac_code}, tuser source
// cfg       in   i_cfg_valid/o_cfg_ready  i_cfg_index, i_cfg_data
// a pot item goes straight to the output register; a tap runs a 16-step serial
// divide for ms, a curve search of up to 20 steps and a 23-step interpolation divide
// ticks and ignored items stay in the front; a two-entry queue separates front and back
// synchronous active-low reset restores register defaults and pot mode
`timescale 1ns / 1ps

module tap_tempo_to_dac_controller import ttdac_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // capture_time[15:0], pot_value[25:16]
    input  logic [1:0]  s_axis_tuser,   // kind
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // dac_code[11:0], interval_ms[22:12]
    output logic        m_axis_tuser    // source
);

    logic q_in_valid, q_in_ready, q_out_valid, q_out_ready;
    t_job q_in_job, q_out_job;
    logic [11:0] code;
    logic [10:0] ivl;

    ttdac_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .i_in_valid(s_axis_tvalid), .o_in_ready(s_axis_tready),
        .i_kind(s_axis_tuser), .i_capture_time(s_axis_tdata[15:0]),
        .i_pot_value(s_axis_tdata[25:16]),
        .o_job_valid(q_in_valid), .i_job_ready(q_in_ready), .o_job(q_in_job)
    );

    ttdac_queue u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_wr_valid(q_in_valid), .o_wr_ready(q_in_ready), .i_wr_job(q_in_job),
        .o_rd_valid(q_out_valid), .i_rd_ready(q_out_ready), .o_rd_job(q_out_job)
    );

    ttdac_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_job_valid(q_out_valid), .o_job_ready(q_out_ready), .i_job(q_out_job),
        .o_valid(m_axis_tvalid), .i_ready(m_axis_tready),
        .o_dac_code(code), .o_source(m_axis_tuser), .o_interval_ms(ivl)
    );

    assign m_axis_tdata = {1'b0, ivl, code};

endmodule
